>>> rtl/core/round_robin_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Round robin task scheduler: assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Constants, codes and controller/datapath interface types for the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);

    localparam int FUNC_W  = 2;
    localparam int TICKS_W = 16;
    localparam int STACK_W = 16;
    localparam int TASK_W  = 3;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DELAY  = 2'd3;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_BLOCKED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WM_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WM_ENABLE    = 2'd1;

    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(TASK_SLOTS - 1);

    typedef struct packed {
        logic              load;
        logic              prep;
        logic              step;
        logic              emit;
        logic [SLOT_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              out_stall;
    } dp_sts_t;

endpackage

>>> rtl/core/rrts_datapath.sv
// ----------------------------------------------------------------------------
// rrts_datapath
// Slot table, stack watermarks, slot walk step logic and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_datapath import rrts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [STACK_W-1:0] wm_threshold_reg;
    logic               wm_enable_reg;

    logic [TASK_SLOTS-1:0] used_reg;
    logic [1:0]            state_reg [TASK_SLOTS];
    logic [TICKS_W-1:0]    block_reg [TASK_SLOTS];
    logic [STACK_W-1:0]    min_reg   [TASK_SLOTS];
    logic [SLOT_W-1:0]     cur_reg;

    logic [FUNC_W-1:0]  func_reg;
    logic [TICKS_W-1:0] delay_reg;
    logic [STACK_W-1:0] sf_reg;

    logic               hit_reg;
    logic [SLOT_W-1:0]  hit_slot_reg;
    logic [STACK_W-1:0] least_reg;
    logic               alarm_reg;

    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    logic               is_switch;
    logic               is_tick;
    logic [SLOT_W:0]    walk_sum;
    logic [SLOT_W-1:0]  walk_slot;
    logic [1:0]         walk_state_next;
    logic               walk_pick;
    logic               create_pick;
    logic [STACK_W-1:0] min_new;
    logic [SLOT_W-1:0]  cur_next;
    logic               none_ready;

    assign cfg_ready = 1'b1;
    assign is_switch = func_reg inside {FUNC_TICK, FUNC_DELAY};
    assign is_tick   = (func_reg == FUNC_TICK);

    always_comb begin
        walk_sum = {1'b0, cur_reg} + (SLOT_W + 1)'(1) + {1'b0, cmd.idx};
        if (walk_sum >= (SLOT_W + 1)'(TASK_SLOTS)) begin
            walk_sum = walk_sum - (SLOT_W + 1)'(TASK_SLOTS);
        end
        walk_slot = (func_reg == FUNC_CREATE) ? cmd.idx : walk_sum[SLOT_W-1:0];
    end

    always_comb begin
        walk_state_next = state_reg[walk_slot];
        if (is_tick && walk_state_next == ST_BLOCKED && block_reg[walk_slot] == '0) begin
            walk_state_next = ST_READY;
        end
        if (walk_slot == cur_reg && walk_state_next == ST_RUNNING) begin
            walk_state_next = ST_READY;
        end
        walk_pick = !hit_reg && used_reg[walk_slot] && walk_state_next == ST_READY;
        if (walk_pick) begin
            walk_state_next = ST_RUNNING;
        end
    end

    assign create_pick = !hit_reg && !used_reg[walk_slot];
    assign min_new     = (sf_reg < min_reg[cur_reg]) ? sf_reg : min_reg[cur_reg];
    assign cur_next    = (is_switch && hit_reg) ? hit_slot_reg : cur_reg;
    assign none_ready  = (func_reg != FUNC_CREATE) && !hit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm_threshold_reg <= '0;
            wm_enable_reg    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_WM_THRESHOLD: wm_threshold_reg <= cfg_data;
                CFG_WM_ENABLE:    wm_enable_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tuser;
            delay_reg <= s_tdata[TICKS_W-1:0];
            sf_reg    <= s_tdata[TICKS_W+STACK_W-1:TICKS_W];
        end
        if (cmd.prep && is_switch) begin
            least_reg <= min_new;
            alarm_reg <= wm_enable_reg && (min_new <= wm_threshold_reg);
        end
        if (cmd.step && ((func_reg == FUNC_CREATE) ? create_pick : walk_pick)) begin
            hit_slot_reg <= walk_slot;
        end
        if (cmd.emit) begin
            m_tdata_reg <= OUT_W'({
                none_ready,
                is_switch ? alarm_reg : 1'b0,
                is_switch ? least_reg : {STACK_W{1'b0}},
                (func_reg == FUNC_CREATE && hit_reg) ? TASK_W'(hit_slot_reg) : {TASK_W{1'b0}},
                (func_reg == FUNC_CREATE) ? hit_reg : 1'b0,
                TASK_W'(cur_next)
            });
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            cur_reg      <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                state_reg[i] <= ST_READY;
                block_reg[i] <= '0;
                min_reg[i]   <= '1;
            end
        end else begin
            if (cmd.load) begin
                hit_reg <= 1'b0;
            end
            if (cmd.prep) begin
                if (func_reg == FUNC_START) begin
                    for (int i = 0; i < TASK_SLOTS; i++) begin
                        if (i == 0 && used_reg[0]) begin
                            state_reg[i] <= ST_RUNNING;
                        end else if (state_reg[i] == ST_RUNNING) begin
                            state_reg[i] <= ST_READY;
                        end
                    end
                    hit_reg <= used_reg[0];
                    cur_reg <= '0;
                end else if (is_switch) begin
                    min_reg[cur_reg] <= min_new;
                    if (func_reg == FUNC_DELAY) begin
                        block_reg[cur_reg] <= delay_reg;
                        state_reg[cur_reg] <= ST_BLOCKED;
                    end
                end
            end
            if (cmd.step) begin
                if (func_reg == FUNC_CREATE) begin
                    if (create_pick) begin
                        used_reg[walk_slot]  <= 1'b1;
                        state_reg[walk_slot] <= ST_READY;
                        block_reg[walk_slot] <= '0;
                        hit_reg              <= 1'b1;
                    end
                end else begin
                    state_reg[walk_slot] <= walk_state_next;
                    if (walk_pick) begin
                        hit_reg <= 1'b1;
                    end
                    if (is_tick && state_reg[walk_slot] == ST_BLOCKED
                            && block_reg[walk_slot] != '0) begin
                        block_reg[walk_slot] <= block_reg[walk_slot] - TICKS_W'(1);
                    end
                end
            end
            if (cmd.emit) begin
                cur_reg      <= cur_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign sts.func      = func_reg;
    assign sts.out_stall = m_tvalid_reg && !m_tready;

endmodule

>>> rtl/core/rrts_ctrl.sv
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer: request capture, preparation step, slot walk and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_defines.svh"

module rrts_ctrl import rrts_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                idx_next = '0;
                state_next = (sts.func == FUNC_START) ? S_DONE : S_WALK;
            end
            S_WALK: begin
                cmd.step = 1'b1;
                if (idx_reg == IDX_LAST) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            S_DONE: begin
                if (!sts.out_stall) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `RRTS_ASSERT_NXT(a_accept_prep, s_tvalid && s_tready, state_reg == S_PREP, "accept not followed by prep")
    `RRTS_ASSERT_NXT(a_walk_end, state_reg == S_WALK && idx_reg == IDX_LAST, state_reg == S_DONE, "walk overran")
    `RRTS_ASSERT_IMP(a_emit_free, cmd.emit, !(sts.out_stall) && m_tready | !sts.out_stall, "emit into busy output")

endmodule

>>> rtl/core/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Eight-slot round robin scheduler with tick delays and stack watermark alarm.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tuser: func; tdata: delay_ticks, stack_free
// m_        out        m_tvalid/m_tready    tdata: scheduling result
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One request at a time: create and switch requests walk every slot, one slot per
// cycle, before the result is formed; start skips the slot walk.
// Synchronous active-low reset clears the slot table; no clearing pass.
// A stalled result sits in the output register; the next request is accepted
// meanwhile and waits at its last step until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_task_scheduler import rrts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // delay_ticks[15:0], stack_free[31:16]
    input  logic [FUNC_W-1:0]     s_tuser,   // func[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // running_task[2:0], created_ok[3],
                                             // created_slot[6:4], least_free[22:7],
                                             // watermark_alarm[23], none_ready[24]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    rrts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrts_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Round robin task scheduler testbench
// Drives create, start, tick and delay requests with random gaps on both
// streams, predicts each scheduling result from a local copy of the slot
// table, and compares every returned result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rrts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 30;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [TICKS_W-1:0] ticks;
        logic [STACK_W-1:0] stack;
    } sched_request_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic               none_ready;
        logic               alarm;
        logic [STACK_W-1:0] least_free;
        logic [TASK_W-1:0]  created_slot;
        logic               created_ok;
        logic [TASK_W-1:0]  running_task;
    } sched_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    round_robin_task_scheduler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the slot table and alarm settings
    logic               task_live  [TASK_SLOTS];
    logic [1:0]         task_state [TASK_SLOTS];
    logic [TICKS_W-1:0] wake_count [TASK_SLOTS];
    logic [STACK_W-1:0] stack_low  [TASK_SLOTS];
    logic [SLOT_W-1:0]  active_slot;
    logic [STACK_W-1:0] alarm_level;
    logic               alarm_on;

    sched_request_t pending_requests[$];
    sched_result_t  expected_schedules[$];

    int requests_queued  = 0;
    int requests_taken   = 0;
    int results_received = 0;
    int error_count      = 0;
    int idle_cycles      = 0;
    int settings_used    = 1;
    int no_ready_seen    = 0;
    int alarms_seen      = 0;
    int send_gap         = 0;
    int recv_stall       = 0;
    bit send_steady      = 0;
    bit recv_steady      = 0;

    always #1 aclk = ~aclk;

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 16);
        else
            return $urandom_range(17, 60);
    endfunction

    function automatic sched_result_t schedule_event(input logic [FUNC_W-1:0] func,
                                                     input logic [TICKS_W-1:0] ticks,
                                                     input logic [STACK_W-1:0] stack);
        sched_result_t res;
        int s;
        int k;
        bit found;
        res   = '0;
        found = 0;
        case (func)
            FUNC_CREATE: begin
                for (s = 0; s < TASK_SLOTS; s++) begin
                    if (!found && !task_live[s]) begin
                        task_live[s]     = 1'b1;
                        task_state[s]    = ST_READY;
                        wake_count[s]    = '0;
                        res.created_ok   = 1'b1;
                        res.created_slot = s[TASK_W-1:0];
                        found            = 1;
                    end
                end
            end
            FUNC_START: begin
                for (s = 0; s < TASK_SLOTS; s++)
                    if (task_state[s] == ST_RUNNING)
                        task_state[s] = ST_READY;
                active_slot = '0;
                if (task_live[0])
                    task_state[0] = ST_RUNNING;
                else
                    res.none_ready = 1'b1;
            end
            default: begin
                if (func == FUNC_DELAY) begin
                    wake_count[active_slot] = ticks;
                    task_state[active_slot] = ST_BLOCKED;
                end
                if (stack < stack_low[active_slot])
                    stack_low[active_slot] = stack;
                res.least_free = stack_low[active_slot];
                res.alarm      = alarm_on && (stack_low[active_slot] <= alarm_level);
                if (func == FUNC_TICK) begin
                    for (s = 0; s < TASK_SLOTS; s++) begin
                        if (task_state[s] == ST_BLOCKED) begin
                            if (wake_count[s] > 0)
                                wake_count[s] = wake_count[s] - 1'b1;
                            else
                                task_state[s] = ST_READY;
                        end
                    end
                end
                if (task_state[active_slot] == ST_RUNNING)
                    task_state[active_slot] = ST_READY;
                res.none_ready = 1'b1;
                for (k = 1; k <= TASK_SLOTS; k++) begin
                    s = (int'(active_slot) + k) % TASK_SLOTS;
                    if (res.none_ready && task_live[s] && task_state[s] == ST_READY) begin
                        active_slot    = s[SLOT_W-1:0];
                        task_state[s]  = ST_RUNNING;
                        res.none_ready = 1'b0;
                    end
                end
            end
        endcase
        res.running_task = active_slot;
        return res;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned seen);
        if (want != seen) begin
            error_count++;
            if (error_count <= 10)
                $display("[%0t] result %0d %s: expected %0h, got %0h",
                         $time, results_received, field, want, seen);
        end
    endfunction

    // request driver
    always @(posedge aclk) begin
        sched_request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_schedules.push_back(
                    schedule_event(s_tuser, s_tdata[TICKS_W-1:0], s_tdata[IN_W-1:TICKS_W]));
                requests_taken++;
                if ($urandom_range(0, 39) == 0)
                    send_steady = !send_steady;
                send_gap = pick_gap(send_steady);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= req.func;
                    s_tdata  <= {req.stack, req.ticks};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        sched_result_t seen;
        sched_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata[$bits(sched_result_t)-1:0];
                if (expected_schedules.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("[%0t] result with no request waiting: %0h", $time, m_tdata);
                end else begin
                    want = expected_schedules.pop_front();
                    check_field("running_task", 32'(want.running_task),
                                32'(seen.running_task));
                    check_field("created_ok", 32'(want.created_ok), 32'(seen.created_ok));
                    check_field("created_slot", 32'(want.created_slot),
                                32'(seen.created_slot));
                    check_field("least_free", 32'(want.least_free), 32'(seen.least_free));
                    check_field("watermark_alarm", 32'(want.alarm), 32'(seen.alarm));
                    check_field("none_ready", 32'(want.none_ready), 32'(seen.none_ready));
                    no_ready_seen += int'(want.none_ready);
                    alarms_seen   += int'(want.alarm);
                end
                results_received++;
                if ($urandom_range(0, 39) == 0)
                    recv_steady = !recv_steady;
                recv_stall = pick_gap(recv_steady);
            end else if (recv_stall == 0 && !recv_steady && $urandom_range(0, 9) == 0) begin
                recv_stall = pick_gap(1'b0);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no progress for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic post(input logic [FUNC_W-1:0] func, input logic [TICKS_W-1:0] ticks,
                        input logic [STACK_W-1:0] stack);
        sched_request_t req;
        req.func  = func;
        req.ticks = ticks;
        req.stack = stack;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    task automatic post_random(input int count, input bit wide_delays);
        int r;
        logic [FUNC_W-1:0]  func;
        logic [TICKS_W-1:0] ticks;
        logic [STACK_W-1:0] stack;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                func = FUNC_CREATE;
            else if (r < 16)
                func = FUNC_START;
            else if (r < 58)
                func = FUNC_TICK;
            else
                func = FUNC_DELAY;
            if (func != FUNC_DELAY || wide_delays)
                ticks = TICKS_W'($urandom);
            else if ($urandom_range(0, 9) == 0)
                ticks = TICKS_W'($urandom_range(5, 40));
            else
                ticks = TICKS_W'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0)
                stack = STACK_W'($urandom);
            else
                stack = 16'hFFFF - STACK_W'($urandom_range(0, 16'h3FFF));
            post(func, ticks, stack);
        end
    endtask

    task automatic wait_idle();
        while (results_received != requests_queued)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WM_THRESHOLD)
            alarm_level = val;
        else if (idx == CFG_WM_ENABLE)
            alarm_on = val[0];
    endtask

    task automatic run_setting(input logic [STACK_W-1:0] level, input logic enable,
                               input int count);
        write_reg(CFG_WM_THRESHOLD, level);
        write_reg(CFG_WM_ENABLE, CFG_DATA_W'(enable));
        settings_used++;
        post_random(count, 1'b0);
        wait_idle();
    endtask

    initial begin
        int s;
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (s = 0; s < TASK_SLOTS; s++) begin
            task_live[s]  = 1'b0;
            task_state[s] = ST_READY;
            wake_count[s] = '0;
            stack_low[s]  = '1;
        end
        active_slot = '0;
        alarm_level = '0;
        alarm_on    = 1'b1;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: tick, start and delay with nothing to run
        post(FUNC_TICK, 16'h0000, 16'h0000);
        post(FUNC_START, 16'hFFFF, 16'hFFFF);
        post(FUNC_DELAY, 16'hFFFF, 16'hFFFF);
        // fill the table, then one create too many
        repeat (TASK_SLOTS + 1)
            post(FUNC_CREATE, 16'h0000, 16'h0000);
        post(FUNC_START, 16'h0000, 16'h0000);
        post(FUNC_TICK, 16'hFFFF, 16'hFFFF);
        // block every slot with a zero delay, the last finds none ready
        repeat (TASK_SLOTS)
            post(FUNC_DELAY, 16'h0000, STACK_W'($urandom));
        post(FUNC_TICK, 16'h0000, 16'h8000);
        post(FUNC_TICK, 16'h0000, 16'h7FFF);
        wait_idle();

        run_setting(16'h8000, 1'b1, 220);
        run_setting(16'hFFFF, 1'b0, 220);
        run_setting(16'h0000, 1'b1, 210);
        run_setting(STACK_W'($urandom), 1'b1, 210);
        write_reg(CFG_WM_THRESHOLD, 16'hFFFF);
        write_reg(CFG_WM_ENABLE, CFG_DATA_W'(1));
        settings_used++;
        post_random(200, 1'b0);
        post_random(8, 1'b1);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests over %0d alarm settings; %0d results with no ready slot,",
                 requests_taken, settings_used, no_ready_seen);
        $display("%0d with the watermark alarm raised; %0d errors, %0d results outstanding",
                 alarms_seen, error_count, expected_schedules.size());
        if (error_count == 0 && expected_schedules.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/rrts_pkg.sv
rtl/core/rrts_datapath.sv
rtl/core/rrts_ctrl.sv
rtl/core/round_robin_task_scheduler.sv
tb/testbench.sv
